[src/md5_pkg.sv]
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       no_data;
    } t_md5_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_md5_out;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by round i.
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

[src/md5_round.sv]
// One MD5 step: takes the working words and the message word, gives new B.
module md5_step import md5_pkg::*; (
    input  logic [5:0]  i_idx,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_w,
    output logic [31:0] o_b
);
    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  sh;
    logic [63:0] dbl;

    always_comb begin
        case (i_idx[5:4])
            2'd0: f = (i_b & i_c) | (~i_b & i_d);
            2'd1: f = (i_b & i_d) | (i_c & ~i_d);
            2'd2: f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
        sum = i_a + f + i_w + round_const(i_idx);
        sh  = rot_amount(i_idx);
        dbl = {sum, sum} << sh;
        o_b = i_b + dbl[63:32];
    end
endmodule

[src/md5_message_digest.sv]
// MD5 digest over a byte stream, one byte per request. The 64th byte of a
// block, or the end of a message, starts the compression, which runs one
// round per cycle out of a 16-word block memory with one registered read port:
// a read lead step, 64 rounds, then the chain update. A message end takes one or two
// padded blocks and then delivers four digest words A to D, one per output
// request, straight from the chain registers. Input is held off while pad
// words are written, a block compresses or the digest drains. Padding rewrites
// the tail of the block in the memory, one word a cycle.
module md5_message_digest import md5_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_md5_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_md5_out o_data
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;  // write pad words
    localparam logic [2:0] ST_RUN  = 3'd2;  // rounds
    localparam logic [2:0] ST_ADD  = 3'd3;  // chain update
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [31:0] mem [16];
    logic [31:0] r_rd;
    logic [2:0]  r_state;
    logic [60:0] r_cnt;
    logic [31:0] r_acc;      // partial word being assembled
    logic [31:0] r_ch [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [6:0]  r_rnd;      // 0 = lead cycle, 1..64 = rounds
    logic        r_fin;      // a message end is in progress
    logic        r_second;   // length-only pad block, or a pad block after full data
    logic [4:0]  r_pw;       // pad word pointer, 16 = done
    logic [5:0]  r_pos;      // position at message end
    logic [63:0] r_bits;
    logic [1:0]  r_oi;
    logic        r_ov;

    logic        take;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [5:0]  pos;
    logic [31:0] word_in;
    logic [31:0] new_b;
    logic [5:0]  ridx;

    assign pos     = r_cnt[5:0];
    assign take    = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign ridx    = 6'(r_rnd - 7'd1);

    md5_step u_round (
        .i_idx(ridx), .i_a(r_a), .i_b(r_b), .i_c(r_c), .i_d(r_d),
        .i_w(r_rd), .o_b(new_b)
    );

    // The byte lands in the assembled word; the word holds bytes below pos.
    always_comb begin
        word_in = (pos[1:0] == 2'd0) ? 32'd0 : r_acc;
        word_in[pos[1:0]*8 +: 8] = i_data.data_byte;
    end

    // Pad word k of the current block.
    function automatic logic [31:0] pad_word(input logic [4:0] k, input logic [5:0] p,
                                             input logic [31:0] acc, input logic second,
                                             input logic [63:0] bits);
        logic [31:0] w;
        w = 32'd0;
        if (!second && k[3:0] == p[5:2]) begin
            w = (p[1:0] == 2'd0) ? 32'd0 : acc;
            w[p[1:0]*8 +: 8] = PAD_MARK;
        end
        if (k[3:0] == 4'd14 && (second || p < 6'd56)) w = bits[31:0];
        if (k[3:0] == 4'd15 && (second || p < 6'd56)) w = bits[63:32];
        return w;
    endfunction

    always_comb begin
        wr_en = 1'b0;
        wr_addr = pos[5:2];
        wr_data = word_in;
        if (r_state == ST_IDLE && take && !i_data.no_data) begin
            wr_en = 1'b1;
        end else if (r_state == ST_PAD) begin
            wr_en = 1'b1;
            wr_addr = r_pw[3:0];
            wr_data = pad_word(r_pw, r_pos, r_acc, r_second, r_bits);
        end
    end

    always_comb begin
        rd_addr = word_sel(6'(r_rnd));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_ch[0] <= INIT_A; r_ch[1] <= INIT_B; r_ch[2] <= INIT_C; r_ch[3] <= INIT_D;
            r_fin <= 1'b0;
            r_second <= 1'b0;
            r_ov <= 1'b0;
            r_oi <= '0;
            r_rnd <= '0;
            r_pw <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (take) begin
                    if (i_data.no_data) begin
                        r_fin <= 1'b1; r_second <= 1'b0; r_pw <= 5'(pos[5:2]);
                        r_pos <= pos; r_bits <= {r_cnt, 3'b000};
                        r_state <= ST_PAD;
                    end else begin
                        r_acc <= word_in;
                        r_cnt <= r_cnt + 61'd1;
                        if (i_data.last_byte) begin
                            r_fin <= 1'b1;
                            r_pos <= 6'(pos + 6'd1);
                            r_bits <= {61'(r_cnt + 61'd1), 3'b000};
                            if (pos == 6'd63) begin
                                r_second <= 1'b1; // whole pad block after data
                                r_pw <= 5'd0;
                                r_state <= ST_RUN; r_rnd <= '0;
                                r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
                            end else begin
                                r_second <= 1'b0;
                                r_pw <= 5'(((pos + 6'd1) >> 2));
                                r_state <= ST_PAD;
                            end
                        end else if (pos == 6'd63) begin
                            r_fin <= 1'b0;
                            r_state <= ST_RUN; r_rnd <= '0;
                            r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
                        end
                    end
                end
                ST_PAD: begin
                    if (r_pw == 5'd15) begin
                        r_state <= ST_RUN; r_rnd <= '0;
                        r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
                    end
                    r_pw <= r_pw + 5'd1;
                end
                ST_RUN: begin
                    if (r_rnd != 7'd0) begin
                        r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= new_b;
                    end
                    if (r_rnd == 7'd64) r_state <= ST_ADD;
                    r_rnd <= r_rnd + 7'd1;
                end
                default: ;
            endcase
            if (r_state == ST_ADD) begin
                r_ch[0] <= r_ch[0] + r_a; r_ch[1] <= r_ch[1] + r_b;
                r_ch[2] <= r_ch[2] + r_c; r_ch[3] <= r_ch[3] + r_d;
                if (!r_fin) begin
                    r_state <= ST_IDLE;
                end else if (r_second && r_pw == 5'd0) begin
                    // A full data block ending a message still needs its pad
                    // block, which starts with the mark at byte zero.
                    r_second <= 1'b0; r_state <= ST_PAD;
                end else if (!r_second && r_pos >= 6'd56) begin
                    // Length does not fit: one more block of zeros and length.
                    r_second <= 1'b1; r_pw <= 5'd0; r_state <= ST_PAD;
                end else begin
                    r_state <= ST_OUT; r_oi <= '0; r_ov <= 1'b1;
                end
            end
            if (r_state == ST_OUT && r_ov && i_ready) begin
                r_oi <= r_oi + 2'd1;
                if (r_oi == 2'd3) begin
                    r_ov <= 1'b0; r_state <= ST_IDLE; r_fin <= 1'b0; r_cnt <= '0;
                    r_ch[0] <= INIT_A; r_ch[1] <= INIT_B;
                    r_ch[2] <= INIT_C; r_ch[3] <= INIT_D;
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data.digest_word = r_ch[r_oi];
    assign o_data.word_index  = r_oi;
    assign o_data.last_word   = (r_oi == 2'd3);
endmodule

[src/md5_checker.sv]
module md5_checker import md5_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input t_md5_in  i_data,
    input logic     o_valid,
    input logic     i_ready,
    input t_md5_out o_data
);
    // No new request is taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken during digest");

    // Digest words come out in order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_word) |=>
        (o_valid && o_data.word_index == 2'($past(o_data.word_index) + 2'd1)))
        else $error("digest word order");

    // The flag marks word D exactly.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 2'd3)))
        else $error("last_word mismatch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output not held");
endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);
